[rtl/core/htp_pkg.sv]
// Shared types, register codes, constants and helpers for the helical tube point evaluator.
package htp_pkg;

   // Input item: grid indices
   typedef struct packed {
      logic [15:0] index_along;
      logic [15:0] index_around;
   } req_type;

   // Result item: Q16.16 point coordinates
   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } rsp_type;

   // Register indexes
   typedef enum logic [3:0] {
      REG_MAJOR_RADIUS = 4'd0,
      REG_MINOR_RADIUS = 4'd1,
      REG_CENTRE_X     = 4'd2,
      REG_CENTRE_Y     = 4'd3,
      REG_CENTRE_Z     = 4'd4,
      REG_PITCH        = 4'd5,
      REG_PHI_STEP     = 4'd6,
      REG_THETA_STEP   = 4'd7
   } reg_index_type;

   // Width of CORDIC datapath (Q2.30 plus guard bits)
   localparam int CW = 34;
   localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   // Arctangent of 2^-k in Q0.32 turns, truncated
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
   };

   // Axial rise side data that rides along the CORDIC
   typedef struct packed {
      logic        neg;
      logic        ovf;
      logic [40:0] mag;
   } rise_type;

   // Clamp a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -48'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

[rtl/core/htp_angle.sv]
// Angle and axial rise front end: index products, pitch product and rounding.
module htp_angle #(
   parameter int INDEX_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  htp_pkg::req_type          in_item,
   input  logic [39:0]               phi_step,
   input  logic [31:0]               theta_step,
   input  logic signed [31:0]        pitch,
   output logic                      out_valid,
   output logic [31:0]               out_phi,
   output logic [31:0]               out_theta,
   output htp_pkg::rise_type         out_rise
);
   import htp_pkg::*;

   localparam int EFF = (INDEX_BITS < 16) ? INDEX_BITS : 16;
   localparam logic [16:0] IMASK_W = (17'd1 << EFF) - 17'd1;
   localparam logic [15:0] IMASK = IMASK_W[15:0];

   logic        v1_ff, v2_ff, v3_ff;
   logic [55:0] turns_ff;
   logic [31:0] theta1_ff;
   logic [31:0] phi2_ff, theta2_ff, phi3_ff, theta3_ff;
   logic [55:0] prod_hi_ff;
   logic [63:0] prod_lo_ff;
   logic        neg2_ff;
   rise_type    rise_ff;

   logic [15:0] i_m, j_m;
   logic [47:0] theta_full;
   logic [31:0] mag_in;
   logic [64:0] lo_round;
   logic [56:0] mag_total;

   assign i_m = in_item.index_along & IMASK;
   assign j_m = in_item.index_around & IMASK;
   assign theta_full = j_m * theta_step;
   assign mag_in = pitch[31] ? 32'(-{pitch[31], pitch}) : 32'(pitch);
   assign lo_round = {1'b0, prod_lo_ff} + 65'h80000000;
   assign mag_total = {1'b0, prod_hi_ff} + {24'd0, lo_round[64:32]};

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Index products, then pitch partial products, then rise sum
   always_ff @(posedge clock) begin
      turns_ff   <= i_m * phi_step;
      theta1_ff  <= theta_full[31:0];
      phi2_ff    <= turns_ff[31:0];
      theta2_ff  <= theta1_ff;
      neg2_ff    <= pitch[31];
      prod_hi_ff <= mag_in * turns_ff[55:32];
      prod_lo_ff <= mag_in * turns_ff[31:0];
      phi3_ff    <= phi2_ff;
      theta3_ff  <= theta2_ff;
      rise_ff.neg <= neg2_ff;
      rise_ff.ovf <= mag_total > 57'h10000000000;
      rise_ff.mag <= mag_total[40:0];
   end

   assign out_valid = v3_ff;
   assign out_phi   = phi3_ff;
   assign out_theta = theta3_ff;
   assign out_rise  = rise_ff;
endmodule

[rtl/core/htp_cordic.sv]
// Pipelined rotation-mode CORDIC in turn units: one iteration per register stage.
module htp_cordic #(
   parameter int STAGES = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [31:0]                   angle,
   output logic                          out_valid,
   output logic signed [htp_pkg::CW-1:0] cos_out,
   output logic signed [htp_pkg::CW-1:0] sin_out
);
   import htp_pkg::*;

   logic signed [CW-1:0] x_ff [STAGES+1];
   logic signed [CW-1:0] y_ff [STAGES+1];
   logic signed [CW-1:0] z_ff [STAGES+1];
   logic                 f_ff [STAGES+1];
   logic                 v_ff [STAGES+1];
   logic signed [CW-1:0] c_ff, s_ff;
   logic                 vo_ff;

   logic signed [CW-1:0] z_in;
   logic signed [CW-1:0] z_fold;
   logic                 flip;

   // Fold angle into a quarter turn either side of zero
   always_comb begin
      z_in = CW'(signed'(angle));
      flip = 1'b0;
      z_fold = z_in;
      if (z_in > 34'sh40000000) begin
         z_fold = z_in - 34'sh80000000;
         flip = 1'b1;
      end else if (z_in < -34'sh40000000) begin
         z_fold = z_in + 34'sh80000000;
         flip = 1'b1;
      end
   end

   // Load first stage
   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= CORDIC_GAIN_Q30;
      y_ff[0] <= '0;
      z_ff[0] <= z_fold;
      f_ff[0] <= flip;
   end

   // Rotate by one arctangent step per stage
   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam logic signed [CW-1:0] ATAN_K = CW'(ATAN_TURNS[k % 32]);
      always_ff @(posedge clock) begin
         if (reset) v_ff[k+1] <= 1'b0;
         else v_ff[k+1] <= v_ff[k];
      end
      always_ff @(posedge clock) begin
         f_ff[k+1] <= f_ff[k];
         if (!z_ff[k][CW-1]) begin
            x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
            y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
            z_ff[k+1] <= z_ff[k] - ATAN_K;
         end else begin
            x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
            y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
            z_ff[k+1] <= z_ff[k] + ATAN_K;
         end
      end
   end

   // Undo fold on the way out
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else vo_ff <= v_ff[STAGES];
   end

   always_ff @(posedge clock) begin
      c_ff <= f_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
      s_ff <= f_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];
   end

   assign out_valid = vo_ff;
   assign cos_out   = c_ff;
   assign sin_out   = s_ff;
endmodule

[rtl/core/htp_mix.sv]
// Back end: tube and ring products, rounding, centre offset and saturation.
module htp_mix (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [htp_pkg::CW-1:0] cp,
   input  logic signed [htp_pkg::CW-1:0] sp,
   input  logic signed [htp_pkg::CW-1:0] ct,
   input  logic signed [htp_pkg::CW-1:0] st,
   input  htp_pkg::rise_type             rise,
   input  logic signed [31:0]            major_radius,
   input  logic signed [31:0]            minor_radius,
   input  logic signed [31:0]            centre_x,
   input  logic signed [31:0]            centre_y,
   input  logic signed [31:0]            centre_z,
   output logic                          out_valid,
   output htp_pkg::rsp_type              out_item
);
   import htp_pkg::*;

   localparam logic signed [70:0] HALF71 = 71'sd536870912;
   localparam logic signed [65:0] HALF66 = 66'sd536870912;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [65:0]   rc_ff, rs_ff;
   logic signed [CW-1:0] cp1_ff, sp1_ff, cp2_ff, sp2_ff;
   rise_type             rise1_ff;
   logic signed [36:0]   ring_ff;
   logic signed [31:0]   z2_ff, z3_ff;
   logic signed [70:0]   px_ff, py_ff;
   rsp_type              out_ff;

   logic signed [65:0] rc_r, rs_r;
   logic signed [36:0] ring_in;
   logic signed [47:0] zbase, zsum;
   logic signed [31:0] z_in;
   logic signed [70:0] px_r, py_r;

   // Round tube terms and form ring radius and z
   always_comb begin
      rc_r = (rc_ff + HALF66) >>> 30;
      rs_r = (rs_ff + HALF66) >>> 30;
      ring_in = 37'(signed'(major_radius)) + 37'(rc_r);
      zbase = 48'(signed'(centre_z)) + 48'(rs_r);
      zsum = rise1_ff.neg ? zbase - 48'(signed'({1'b0, rise1_ff.mag}))
                          : zbase + 48'(signed'({1'b0, rise1_ff.mag}));
      if (rise1_ff.ovf) z_in = rise1_ff.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
      else z_in = sat32(zsum);
      px_r = (px_ff + HALF71) >>> 30;
      py_r = (py_ff + HALF71) >>> 30;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Stage data through products, sums and saturation
   always_ff @(posedge clock) begin
      rc_ff    <= 66'(minor_radius) * 66'(ct);
      rs_ff    <= 66'(minor_radius) * 66'(st);
      cp1_ff   <= cp;
      sp1_ff   <= sp;
      rise1_ff <= rise;
      ring_ff  <= ring_in;
      z2_ff    <= z_in;
      cp2_ff   <= cp1_ff;
      sp2_ff   <= sp1_ff;
      px_ff    <= 71'(ring_ff) * 71'(cp2_ff);
      py_ff    <= 71'(ring_ff) * 71'(sp2_ff);
      z3_ff    <= z2_ff;
      out_ff.point_x <= sat32(48'(signed'(centre_x)) + 48'(px_r));
      out_ff.point_y <= sat32(48'(signed'(centre_y)) + 48'(py_r));
      out_ff.point_z <= z3_ff;
   end

   assign out_valid = v4_ff;
   assign out_item  = out_ff;
endmodule

[rtl/core/helix_tube_point_eval.sv]
// Top level of the helical tube point evaluator: registers, pipeline and side data delay.
// Takes one index pair per clock (busy stays low) and returns one Q16.16 point per item,
// marked by rsp_valid for one cycle; the receiver cannot stall. The pipeline is made of
// the CORDIC iteration stages plus its load and unfold stages (two), three front-end
// stages (index and pitch products) and four back-end stages (radius products and
// saturation).
// Register writes are taken at any time on the csr port but belong to idle periods.
module helix_tube_point_eval #(
   parameter int INDEX_BITS    = 16,
   parameter int CORDIC_STAGES = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  htp_pkg::req_type req_data,
   output logic             rsp_valid,
   output htp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_index,
   input  logic [39:0]      csr_data
);
   import htp_pkg::*;

   localparam int DLY = CORDIC_STAGES + 2;

   logic signed [31:0] major_ff, minor_ff, cx_ff, cy_ff, cz_ff, pitch_ff;
   logic [39:0]        phi_step_ff;
   logic [31:0]        theta_step_ff;

   logic                 a_valid, cp_valid, ct_valid;
   logic [31:0]          a_phi, a_theta;
   rise_type             a_rise;
   logic signed [CW-1:0] cp, sp, ct, st;
   rise_type             rise_dly_ff [DLY];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff      <= '0;
         minor_ff      <= '0;
         cx_ff         <= '0;
         cy_ff         <= '0;
         cz_ff         <= '0;
         pitch_ff      <= '0;
         phi_step_ff   <= '0;
         theta_step_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAJOR_RADIUS: major_ff      <= csr_data[31:0];
            REG_MINOR_RADIUS: minor_ff      <= csr_data[31:0];
            REG_CENTRE_X:     cx_ff         <= csr_data[31:0];
            REG_CENTRE_Y:     cy_ff         <= csr_data[31:0];
            REG_CENTRE_Z:     cz_ff         <= csr_data[31:0];
            REG_PITCH:        pitch_ff      <= csr_data[31:0];
            REG_PHI_STEP:     phi_step_ff   <= csr_data;
            REG_THETA_STEP:   theta_step_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   htp_angle #(.INDEX_BITS(INDEX_BITS)) u_angle (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .in_item    (req_data),
      .phi_step   (phi_step_ff),
      .theta_step (theta_step_ff),
      .pitch      (pitch_ff),
      .out_valid  (a_valid),
      .out_phi    (a_phi),
      .out_theta  (a_theta),
      .out_rise   (a_rise)
   );

   htp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_phi (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .angle     (a_phi),
      .out_valid (cp_valid),
      .cos_out   (cp),
      .sin_out   (sp)
   );

   htp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_theta (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .angle     (a_theta),
      .out_valid (ct_valid),
      .cos_out   (ct),
      .sin_out   (st)
   );

   // Delay rise data to line up with the CORDIC outputs
   always_ff @(posedge clock) begin
      rise_dly_ff[0] <= a_rise;
      for (int k = 1; k < DLY; k++) rise_dly_ff[k] <= rise_dly_ff[k-1];
   end

   htp_mix u_mix (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (cp_valid && ct_valid),
      .cp           (cp),
      .sp           (sp),
      .ct           (ct),
      .st           (st),
      .rise         (rise_dly_ff[DLY-1]),
      .major_radius (major_ff),
      .minor_radius (minor_ff),
      .centre_x     (cx_ff),
      .centre_y     (cy_ff),
      .centre_z     (cz_ff),
      .out_valid    (rsp_valid),
      .out_item     (rsp_data)
   );
endmodule

[sim/helix_tube_point_eval_test.sv]
// Self-checking testbench for the helical tube point evaluator.
module helix_tube_point_eval_test;
   import htp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY  = 24 + 9;
   localparam int WATCHDOG = 20000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [3:0] csr_index;
   logic [39:0] csr_data;

   helix_tube_point_eval i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copy of the registers
   logic signed [31:0] major_r, minor_r, cen_x, cen_y, cen_z, rise_pitch;
   logic [39:0] phi_step;
   logic [31:0] theta_step;

   req_type pending_items[$];
   rsp_type expected_points[$];
   int failures;
   int idle_cycles;
   int gap_left;
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint floor_shift(longint v, int k);
      return v >>> k;
   endfunction

   // Rotation CORDIC on a Q0.32 turn angle, outputs Q2.30
   function automatic void rotate_turns(input logic [31:0] angle,
                                        output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'($signed(angle));
      flip = 0;
      x = 652032874;
      y = 0;
      if (z > 64'sh40000000) begin
         z -= 64'sh80000000;
         flip = 1;
      end else if (z < -64'sh40000000) begin
         z += 64'sh80000000;
         flip = 1;
      end
      for (int k = 0; k < 24; k++) begin
         dx = floor_shift(y, k);
         dy = floor_shift(x, k);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURNS[k]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURNS[k]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint scale_q30(longint a, longint b);
      return (a * b + 64'sd536870912) >>> 30;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Compute the expected point for one index pair
   function automatic rsp_type tube_point(req_type item);
      logic [63:0] turns, mag;
      logic [31:0] theta;
      longint cp, sp, ct, st, rc, rs, ring, zbase, p;
      bit neg;
      rsp_type pt;
      turns = 64'(item.index_along) * 64'(phi_step);
      theta = 32'(64'(item.index_around) * 64'(theta_step));
      rotate_turns(turns[31:0], cp, sp);
      rotate_turns(theta, ct, st);
      rc = scale_q30(longint'(minor_r), ct);
      rs = scale_q30(longint'(minor_r), st);
      ring = longint'(major_r) + rc;
      pt.point_x = clamp32(longint'(cen_x) + scale_q30(ring, cp));
      pt.point_y = clamp32(longint'(cen_y) + scale_q30(ring, sp));
      p = longint'(rise_pitch);
      neg = p < 0;
      mag = neg ? 64'(-p) : 64'(p);
      mag = mag * (turns >> 32) + ((mag * {32'd0, turns[31:0]} + 64'h80000000) >> 32);
      zbase = longint'(cen_z) + rs;
      if (mag > (64'd1 << 40)) pt.point_z = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
      else pt.point_z = clamp32(neg ? zbase - longint'(mag) : zbase + longint'(mag));
      return pt;
   endfunction

   // Write one register through the csr channel and the shadow copy
   task automatic write_reg(reg_index_type idx, logic [39:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_MAJOR_RADIUS: major_r = value[31:0];
         REG_MINOR_RADIUS: minor_r = value[31:0];
         REG_CENTRE_X:     cen_x = value[31:0];
         REG_CENTRE_Y:     cen_y = value[31:0];
         REG_CENTRE_Z:     cen_z = value[31:0];
         REG_PITCH:        rise_pitch = value[31:0];
         REG_PHI_STEP:     phi_step = value;
         REG_THETA_STEP:   theta_step = value[31:0];
         default: ;
      endcase
   endtask

   // Wait until the pipeline has drained
   task automatic drain();
      while (pending_items.size() != 0 || expected_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] edge_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'hFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_item(logic [15:0] a, logic [15:0] b);
      req_type it;
      it.index_along = a;
      it.index_around = b;
      pending_items.push_back(it);
   endtask

   task automatic random_setting(int mode);
      if (mode == 0) begin
         // moderate geometry, no saturation in x and y
         write_reg(REG_MAJOR_RADIUS, 40'($signed($urandom_range(0, 32'h01000000)) - 32'sh00800000));
         write_reg(REG_MINOR_RADIUS, 40'($signed($urandom_range(0, 32'h00800000)) - 32'sh00400000));
         write_reg(REG_CENTRE_X, 40'($signed($urandom_range(0, 32'h02000000)) - 32'sh01000000));
         write_reg(REG_CENTRE_Y, 40'($signed($urandom_range(0, 32'h02000000)) - 32'sh01000000));
         write_reg(REG_CENTRE_Z, 40'($signed($urandom_range(0, 32'h02000000)) - 32'sh01000000));
         write_reg(REG_PITCH, 40'($signed($urandom_range(0, 32'h00040000)) - 32'sh00020000));
         write_reg(REG_PHI_STEP, {8'd0, 32'($urandom)});
      end else begin
         write_reg(REG_MAJOR_RADIUS, 40'(edge_value()));
         write_reg(REG_MINOR_RADIUS, 40'(edge_value()));
         write_reg(REG_CENTRE_X, 40'(edge_value()));
         write_reg(REG_CENTRE_Y, 40'(edge_value()));
         write_reg(REG_CENTRE_Z, 40'(edge_value()));
         write_reg(REG_PITCH, 40'(edge_value()));
         write_reg(REG_PHI_STEP, {8'($urandom), 32'($urandom)});
      end
      write_reg(REG_THETA_STEP, 40'($urandom));
   endtask

   // Stimulus and end of run
   initial begin
      major_r = 0; minor_r = 0; cen_x = 0; cen_y = 0; cen_z = 0; rise_pitch = 0;
      phi_step = 0; theta_step = 0;
      failures = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero steps keep both angles at 0
      write_reg(REG_MAJOR_RADIUS, 40'h0000030000);
      write_reg(REG_MINOR_RADIUS, 40'h0000010000);
      push_item(16'h0000, 16'h0000);
      push_item(16'hFFFF, 16'hFFFF);
      drain();
      // directed geometry with angle wrap and full pitch rise
      write_reg(REG_CENTRE_X, 40'h00000A0000);
      write_reg(REG_CENTRE_Y, 40'hFFFFF60000);
      write_reg(REG_CENTRE_Z, 40'h0000010000);
      write_reg(REG_PITCH, 40'h0000020000);
      write_reg(REG_PHI_STEP, 40'h0040000000);
      write_reg(REG_THETA_STEP, 40'h0020000000);
      for (int k = 0; k < 8; k++) push_item(16'(k), 16'(k));
      push_item(16'hFFFF, 16'h0000);
      push_item(16'h0000, 16'hFFFF);
      push_item(16'h5555, 16'hAAAA);
      push_item(16'hAAAA, 16'h5555);
      drain();
      // degenerate torus and saturation extremes
      write_reg(REG_MAJOR_RADIUS, 40'h0080000000);
      write_reg(REG_MINOR_RADIUS, 40'h007FFFFFFF);
      write_reg(REG_CENTRE_X, 40'h007FFFFFFF);
      write_reg(REG_CENTRE_Y, 40'h0080000000);
      write_reg(REG_PITCH, 40'h0080000000);
      write_reg(REG_PHI_STEP, 40'hFFFFFFFFFF);
      write_reg(REG_THETA_STEP, 40'hFFFFFFFF);
      push_item(16'h0001, 16'h0001);
      push_item(16'hFFFF, 16'hFFFF);
      push_item(16'h8000, 16'h7FFF);
      drain();
      write_reg(REG_PITCH, 40'h007FFFFFFF);
      push_item(16'hFFFF, 16'h1234);
      push_item(16'h0003, 16'h8000);
      drain();

      // random phases across several settings
      for (int ph = 0; ph < 12; ph++) begin
         drain();
         random_setting(ph % 3 == 2);
         repeat (95) push_item(16'($urandom), 16'($urandom));
      end
      drain();

      if (failures == 0) $display("helix_tube_point_eval verification clean");
      else $display("helix_tube_point_eval verification failed");
      $finish;
   end

   // Drive items in bursts separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
         burst_left <= 0;
      end else begin
         if (start && !busy) begin
            expected_points.push_back(tube_point(req_data));
            void'(pending_items.pop_front());
         end
         if (pending_items.size() != 0) begin
            if (start && busy) begin
               start <= 1'b1;
            end else if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else begin
               start <= 1'b1;
               req_data <= pending_items[0];
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(0, 30);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Check each result against the oldest expected point
   always @(posedge clock) begin
      rsp_type exp_pt;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_points.size() == 0) begin
               $error("unexpected result point_x=%0d", rsp_data.point_x);
               failures++;
            end else begin
               exp_pt = expected_points.pop_front();
               if (rsp_data.point_x !== exp_pt.point_x) begin
                  $error("point_x expected %0d actual %0d", exp_pt.point_x, rsp_data.point_x);
                  failures++;
               end
               if (rsp_data.point_y !== exp_pt.point_y) begin
                  $error("point_y expected %0d actual %0d", exp_pt.point_y, rsp_data.point_y);
                  failures++;
               end
               if (rsp_data.point_z !== exp_pt.point_z) begin
                  $error("point_z expected %0d actual %0d", exp_pt.point_z, rsp_data.point_z);
                  failures++;
               end
            end
         end
         // watchdog on stalled progress
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG) begin
            $display("helix_tube_point_eval verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

endmodule
